[rtl/pic_pkg.sv]
`default_nettype none
// pic_pkg: constants, codes and shared types of the priority interrupt controller.
// No dependencies; used by the channel interfaces, pic_cell and the top level.
package pic_pkg;

   localparam int NUM_SOURCES = 40;

   localparam int SRC_W  = 6;
   localparam int REG_W  = 7;
   localparam int PRIO_W = 4;
   localparam int BYTE_W = 8;

   localparam int DISABLE_BIT = 6;

   localparam logic [BYTE_W-1:0] NO_SOURCE = 8'hFF;

   localparam logic [1:0] CMD_RAISE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;

   localparam logic [REG_W-1:0] REG_CURRENT   = REG_W'(NUM_SOURCES);
   localparam logic [REG_W-1:0] REG_THRESHOLD = REG_W'(NUM_SOURCES + 1);
   localparam logic [REG_W-1:0] REG_SAVED     = REG_W'(NUM_SOURCES + 2);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DONE
   } state_type;

   // static controls broadcast to every cell for the duration of a sweep
   typedef struct packed {
      logic              raise;
      logic [SRC_W-1:0]  src;
      logic              wr_en;
      logic              rd_en;
      logic [SRC_W-1:0]  idx;
      logic [BYTE_W-1:0] data;
      logic              clr;
      logic [SRC_W-1:0]  clr_src;
      logic [PRIO_W-1:0] thr;
   } cell_ctl_type;

   // token walking the chain, one cell per cycle
   typedef struct packed {
      logic              run;
      logic              found;
      logic              hit;
      logic [PRIO_W-1:0] prio;
      logic [SRC_W-1:0]  idx;
      logic [BYTE_W-1:0] rdata;
   } token_type;

endpackage
`default_nettype wire

[rtl/pic_req_if.sv]
`default_nettype none
// pic_req_if: request channel carrying one command beat.
// Depends on pic_pkg for field widths.
interface pic_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     req_command;
   logic [pic_pkg::SRC_W-1:0]      req_source;
   logic [pic_pkg::SRC_W-1:0]      req_reg_index;
   logic [pic_pkg::BYTE_W-1:0]     req_write_data;

   modport source (output valid, req_command, req_source, req_reg_index, req_write_data,
                   input ready);
   modport sink   (input valid, req_command, req_source, req_reg_index, req_write_data,
                   output ready);
endinterface
`default_nettype wire

[rtl/pic_rsp_if.sv]
`default_nettype none
// pic_rsp_if: response channel carrying read data and the IRQ level.
// Depends on pic_pkg for field widths.
interface pic_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pic_pkg::BYTE_W-1:0]  rsp_read_data;
   logic                        rsp_irq_line;

   modport source (output valid, rsp_read_data, rsp_irq_line, input ready);
   modport sink   (input valid, rsp_read_data, rsp_irq_line, output ready);
endinterface
`default_nettype wire

[rtl/pic_cell.sv]
`default_nettype none
// pic_cell: one interrupt source - enable byte, pending bit and one token stage.
// Depends on pic_pkg.
module pic_cell (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [pic_pkg::SRC_W-1:0]  cell_id,
   input  wire pic_pkg::cell_ctl_type      ctl,
   input  wire pic_pkg::token_type         tok_in,
   output pic_pkg::token_type              tok_out
);

   logic [pic_pkg::BYTE_W-1:0] enable_ff, enable_in;
   logic                       pending_ff, pending_in;
   pic_pkg::token_type         tok_ff, tok_in_next;

   logic me_raise;
   logic me_clr;
   logic pend_eff;
   logic cand;

   always_comb begin
      me_raise = ctl.raise && (ctl.src == cell_id) && !enable_ff[pic_pkg::DISABLE_BIT];
      me_clr   = ctl.clr && (ctl.clr_src == cell_id);
      pend_eff = (pending_ff || me_raise) && !me_clr;
      cand     = pend_eff && !enable_ff[pic_pkg::DISABLE_BIT]
                 && (enable_ff[pic_pkg::PRIO_W-1:0] < ctl.thr);

      enable_in   = enable_ff;
      pending_in  = pending_ff;
      tok_in_next = tok_in;

      if (tok_in.run) begin
         pending_in = pend_eff;
         if (ctl.wr_en && (ctl.idx == cell_id)) begin
            enable_in = ctl.data;
         end
         if (ctl.rd_en && (ctl.idx == cell_id)) begin
            tok_in_next.rdata = enable_ff;
         end
         if (me_raise) begin
            tok_in_next.hit = 1'b1;
         end
         // strict compare keeps the lowest index on equal priority
         if (cand && (!tok_in.found || (enable_ff[pic_pkg::PRIO_W-1:0] < tok_in.prio))) begin
            tok_in_next.found = 1'b1;
            tok_in_next.prio  = enable_ff[pic_pkg::PRIO_W-1:0];
            tok_in_next.idx   = cell_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= '0;
         pending_ff <= 1'b0;
         tok_ff     <= '0;
      end else begin
         enable_ff  <= enable_in;
         pending_ff <= pending_in;
         tok_ff     <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

[rtl/priority_interrupt_controller.sv]
`default_nettype none
// priority_interrupt_controller: command decode, register file and a chain of
// NUM_SOURCES cells that a token walks once per command. Depends on pic_pkg,
// pic_req_if, pic_rsp_if and pic_cell.
// A new beat is taken only after the token has passed every cell and the result is loaded into the output register.
// A finished result waits in the output register while the next beat is taken.
// Reset (synchronous): enables, pending bits and thresholds clear, no source current.
module priority_interrupt_controller (
   input  wire logic  clock,
   input  wire logic  reset,
   pic_req_if.sink    req,
   pic_rsp_if.source  rsp
);

   pic_pkg::state_type state_ff, state_in;

   logic                         launch_ff, launch_in;
   logic [1:0]                   cmd_ff, cmd_in;
   logic [pic_pkg::SRC_W-1:0]    src_ff, src_in;
   logic [pic_pkg::SRC_W-1:0]    idx_ff, idx_in;
   logic [pic_pkg::BYTE_W-1:0]   data_ff, data_in;
   logic                         clr_ff, clr_in;
   logic [pic_pkg::SRC_W-1:0]    clr_src_ff, clr_src_in;
   logic [pic_pkg::BYTE_W-1:0]   rd_local_ff, rd_local_in;
   logic [pic_pkg::BYTE_W-1:0]   hold_rdata_ff, hold_rdata_in;

   logic [pic_pkg::BYTE_W-1:0]   current_ff, current_in;
   logic [pic_pkg::PRIO_W-1:0]   threshold_ff, threshold_in;
   logic [pic_pkg::PRIO_W-1:0]   saved_ff, saved_in;
   logic                         irq_ff, irq_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [pic_pkg::BYTE_W-1:0]   rsp_rdata_ff, rsp_rdata_in;
   logic                         rsp_irq_ff, rsp_irq_in;

   logic accept;
   logic sweep_end;
   logic load;
   logic [pic_pkg::REG_W-1:0] acc_idx;
   logic [pic_pkg::REG_W-1:0] item_idx;

   pic_pkg::cell_ctl_type ctl;
   pic_pkg::token_type    tok [pic_pkg::NUM_SOURCES+1];

   // cell chain
   assign tok[0] = '{run: launch_ff, default: '0};

   assign ctl.raise   = (cmd_ff == pic_pkg::CMD_RAISE);
   assign ctl.src     = src_ff;
   assign ctl.wr_en   = (cmd_ff == pic_pkg::CMD_WRITE);
   assign ctl.rd_en   = (cmd_ff == pic_pkg::CMD_READ);
   assign ctl.idx     = idx_ff;
   assign ctl.data    = data_ff;
   assign ctl.clr     = clr_ff;
   assign ctl.clr_src = clr_src_ff;
   assign ctl.thr     = threshold_ff;

   for (genvar i = 0; i < pic_pkg::NUM_SOURCES; i++) begin : g_cell
      pic_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cell_id (pic_pkg::SRC_W'(i)),
         .ctl     (ctl),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1])
      );
   end

   // handshake qualifiers
   assign accept    = req.valid && req.ready;
   assign sweep_end = (state_ff == pic_pkg::ST_SWEEP) && tok[pic_pkg::NUM_SOURCES].run;
   assign load      = (state_ff == pic_pkg::ST_DONE) && (!rsp_valid_ff || rsp.ready);
   assign acc_idx   = {1'b0, req.req_reg_index};
   assign item_idx  = {1'b0, idx_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pic_pkg::ST_IDLE:  if (accept) state_in = pic_pkg::ST_SWEEP;
         pic_pkg::ST_SWEEP: if (sweep_end) state_in = pic_pkg::ST_DONE;
         pic_pkg::ST_DONE:  if (load) state_in = pic_pkg::ST_IDLE;
         default:           state_in = pic_pkg::ST_IDLE;
      endcase
   end

   // state machine outputs
   always_comb begin
      unique case (state_ff)
         pic_pkg::ST_IDLE: req.ready = 1'b1;
         default:          req.ready = 1'b0;
      endcase
   end

   // datapath
   always_comb begin
      launch_in     = accept;
      cmd_in        = cmd_ff;
      src_in        = src_ff;
      idx_in        = idx_ff;
      data_in       = data_ff;
      clr_in        = clr_ff;
      clr_src_in    = clr_src_ff;
      rd_local_in   = rd_local_ff;
      hold_rdata_in = hold_rdata_ff;
      current_in    = current_ff;
      threshold_in  = threshold_ff;
      saved_in      = saved_ff;
      irq_in        = irq_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_rdata_in  = rsp_rdata_ff;
      rsp_irq_in    = rsp_irq_ff;

      if (accept) begin
         cmd_in      = req.req_command;
         src_in      = req.req_source;
         idx_in      = req.req_reg_index;
         data_in     = req.req_write_data;
         clr_in      = 1'b0;
         clr_src_in  = current_ff[pic_pkg::SRC_W-1:0];
         rd_local_in = '0;
         if (req.req_command == pic_pkg::CMD_READ) begin
            unique case (acc_idx)
               pic_pkg::REG_CURRENT: begin
                  rd_local_in = current_ff;
                  if (current_ff != pic_pkg::NO_SOURCE) threshold_in = '0;
               end
               pic_pkg::REG_THRESHOLD: rd_local_in = {4'b0, threshold_ff};
               pic_pkg::REG_SAVED:     rd_local_in = {4'b0, saved_ff};
               default:                rd_local_in = '0;
            endcase
         end
         if ((req.req_command == pic_pkg::CMD_WRITE) && (acc_idx == pic_pkg::REG_THRESHOLD)) begin
            threshold_in = req.req_write_data[pic_pkg::PRIO_W-1:0];
            if (current_ff != pic_pkg::NO_SOURCE) begin
               clr_in     = 1'b1;
               current_in = pic_pkg::NO_SOURCE;
               irq_in     = 1'b0;
            end
         end
      end

      if (sweep_end) begin
         if ((((cmd_ff == pic_pkg::CMD_RAISE) && tok[pic_pkg::NUM_SOURCES].hit) || clr_ff)
             && (current_ff == pic_pkg::NO_SOURCE)) begin
            if (tok[pic_pkg::NUM_SOURCES].found) begin
               current_in = {2'b0, tok[pic_pkg::NUM_SOURCES].idx};
               saved_in   = threshold_ff;
               irq_in     = 1'b1;
            end else begin
               irq_in     = 1'b0;
            end
         end
         if ((cmd_ff == pic_pkg::CMD_READ) && (item_idx < pic_pkg::REG_CURRENT)) begin
            hold_rdata_in = tok[pic_pkg::NUM_SOURCES].rdata;
         end else begin
            hold_rdata_in = rd_local_ff;
         end
      end

      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_rdata_in = hold_rdata_ff;
         rsp_irq_in   = irq_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pic_pkg::ST_IDLE;
         launch_ff     <= 1'b0;
         cmd_ff        <= '0;
         src_ff        <= '0;
         idx_ff        <= '0;
         data_ff       <= '0;
         clr_ff        <= 1'b0;
         clr_src_ff    <= '0;
         rd_local_ff   <= '0;
         hold_rdata_ff <= '0;
         current_ff    <= pic_pkg::NO_SOURCE;
         threshold_ff  <= '0;
         saved_ff      <= '0;
         irq_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_rdata_ff  <= '0;
         rsp_irq_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         launch_ff     <= launch_in;
         cmd_ff        <= cmd_in;
         src_ff        <= src_in;
         idx_ff        <= idx_in;
         data_ff       <= data_in;
         clr_ff        <= clr_in;
         clr_src_ff    <= clr_src_in;
         rd_local_ff   <= rd_local_in;
         hold_rdata_ff <= hold_rdata_in;
         current_ff    <= current_in;
         threshold_ff  <= threshold_in;
         saved_ff      <= saved_in;
         irq_ff        <= irq_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_rdata_ff  <= rsp_rdata_in;
         rsp_irq_ff    <= rsp_irq_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.rsp_read_data = rsp_rdata_ff;
   assign rsp.rsp_irq_line  = rsp_irq_ff;

endmodule
`default_nettype wire
